>>> design/rthp_pkg.sv
// Shared types and constants of the RGB to HSV pixel pipeline.
package rthp_pkg;

    // Channel width and the divider shape that follows from it
    localparam int PIX_W     = 8;
    localparam int DIV_STEPS = PIX_W;
    localparam int NUM_W     = 2 * PIX_W;

    // Hue offsets in half degrees
    localparam logic [PIX_W-1:0] HUE_BLUE  = PIX_W'(120);
    localparam logic [PIX_W-1:0] HUE_GREEN = PIX_W'(60);
    localparam logic [PIX_W-1:0] HUE_WRAP  = PIX_W'(180);
    localparam logic [PIX_W-1:0] HUE_MAX   = PIX_W'(179);

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_BLUE,
        SEC_GREEN,
        SEC_RED
    } t_sector;

    // Word carried through the divider stages: two restoring divisions in step
    typedef struct packed {
        t_sector              sector;
        logic                 neg;
        logic                 zero;
        logic [PIX_W-1:0]     bright;
        logic [NUM_W-1:0]     hue_rem;
        logic [NUM_W-1:0]     hue_dsh;
        logic [PIX_W-1:0]     hue_q;
        logic [NUM_W-1:0]     sat_rem;
        logic [NUM_W-1:0]     sat_dsh;
        logic [PIX_W-1:0]     sat_q;
    } t_div_word;

endpackage

>>> design/rthp_if.sv
// Pixel input and HSV output channel interfaces.
interface rthp_pix_if;
    logic                      valid;
    logic                      ready;
    logic [rthp_pkg::PIX_W-1:0] blue;
    logic [rthp_pkg::PIX_W-1:0] green;
    logic [rthp_pkg::PIX_W-1:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface rthp_hsv_if;
    logic                      valid;
    logic                      ready;
    logic [rthp_pkg::PIX_W-1:0] hue;
    logic [rthp_pkg::PIX_W-1:0] saturation;
    logic [rthp_pkg::PIX_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

>>> design/rthp_front.sv
// Front stages: pick the maximum channel, form delta, then the two dividends.
module rthp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rthp_pix_if.sink            i_pix,
    output logic                o_valid,
    output rthp_pkg::t_div_word o_word,
    input  logic                i_ready
);

    typedef struct packed {
        rthp_pkg::t_sector           sector;
        logic                        neg;
        logic [rthp_pkg::PIX_W-1:0]  mx;
        logic [rthp_pkg::PIX_W-1:0]  delta;
        logic [rthp_pkg::PIX_W-1:0]  mag;
    } t_sort_word;

    logic                       r_s1_valid;
    t_sort_word                 r_s1;
    t_sort_word                 n_s1;
    logic                       r_s2_valid;
    rthp_pkg::t_div_word        r_s2;
    rthp_pkg::t_div_word        n_s2;
    logic                       s1_ready;
    logic                       s2_ready;
    logic [rthp_pkg::PIX_W-1:0] o1;
    logic [rthp_pkg::PIX_W-1:0] o2;
    logic [rthp_pkg::PIX_W-1:0] mn;

    // Advance a stage when it is empty or the next one takes its word
    assign s2_ready    = !r_s2_valid || i_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_ready;

    // Select maximum: green wins ties over blue, red wins ties over either
    always_comb begin
        n_s1 = '0;
        if (i_pix.blue > i_pix.green) begin
            n_s1.sector = rthp_pkg::SEC_BLUE;
            n_s1.mx     = i_pix.blue;
        end else begin
            n_s1.sector = rthp_pkg::SEC_GREEN;
            n_s1.mx     = i_pix.green;
        end
        if (!(n_s1.mx > i_pix.red)) begin
            n_s1.sector = rthp_pkg::SEC_RED;
            n_s1.mx     = i_pix.red;
        end
        // o2 - o1 is the signed hue difference of the sector
        case (n_s1.sector)
            rthp_pkg::SEC_BLUE: begin
                o1 = i_pix.green;
                o2 = i_pix.red;
            end
            rthp_pkg::SEC_GREEN: begin
                o1 = i_pix.red;
                o2 = i_pix.blue;
            end
            default: begin
                o1 = i_pix.blue;
                o2 = i_pix.green;
            end
        endcase
        mn         = (o1 < o2) ? o1 : o2;
        n_s1.delta = n_s1.mx - mn;
        n_s1.neg   = (o2 < o1);
        n_s1.mag   = n_s1.neg ? (o1 - o2) : (o2 - o1);
    end

    // Build dividends: 30 * |diff| over delta, 255 * delta over max
    always_comb begin
        n_s2         = '0;
        n_s2.sector  = r_s1.sector;
        n_s2.neg     = r_s1.neg;
        n_s2.zero    = (r_s1.delta == '0);
        n_s2.bright  = r_s1.mx;
        n_s2.hue_rem = (rthp_pkg::NUM_W'(r_s1.mag) << 5) - (rthp_pkg::NUM_W'(r_s1.mag) << 1);
        n_s2.hue_dsh = rthp_pkg::NUM_W'(r_s1.delta) << (rthp_pkg::DIV_STEPS - 1);
        n_s2.sat_rem = (rthp_pkg::NUM_W'(r_s1.delta) << rthp_pkg::PIX_W)
                       - rthp_pkg::NUM_W'(r_s1.delta);
        n_s2.sat_dsh = rthp_pkg::NUM_W'(r_s1.mx) << (rthp_pkg::DIV_STEPS - 1);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_pix.valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_pix.valid) begin
            r_s1 <= n_s1;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_word  = r_s2;

endmodule

>>> design/rthp_div_stage.sv
// One restoring division step for both the hue and the saturation quotient.
module rthp_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rthp_pkg::t_div_word i_word,
    output logic                o_ready,
    output logic                o_valid,
    output rthp_pkg::t_div_word o_word,
    input  logic                i_ready
);

    logic                r_valid;
    rthp_pkg::t_div_word r_word;
    rthp_pkg::t_div_word n_word;
    logic                hue_ge;
    logic                sat_ge;

    assign o_ready = !r_valid || i_ready;

    // Subtract the shifted divisor where it fits, shift in the quotient bit
    always_comb begin
        n_word  = i_word;
        hue_ge  = (i_word.hue_rem >= i_word.hue_dsh);
        sat_ge  = (i_word.sat_rem >= i_word.sat_dsh);
        if (hue_ge) begin
            n_word.hue_rem = i_word.hue_rem - i_word.hue_dsh;
        end
        if (sat_ge) begin
            n_word.sat_rem = i_word.sat_rem - i_word.sat_dsh;
        end
        n_word.hue_q   = {i_word.hue_q[rthp_pkg::PIX_W-2:0], hue_ge};
        n_word.sat_q   = {i_word.sat_q[rthp_pkg::PIX_W-2:0], sat_ge};
        n_word.hue_dsh = i_word.hue_dsh >> 1;
        n_word.sat_dsh = i_word.sat_dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> design/rthp_back.sv
// Output stage: sector offset and sign correction of hue, output register.
module rthp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rthp_pkg::t_div_word i_word,
    output logic                o_ready,
    rthp_hsv_if.source          o_hsv
);

    logic                       r_valid;
    logic [rthp_pkg::PIX_W-1:0] r_hue;
    logic [rthp_pkg::PIX_W-1:0] r_sat;
    logic [rthp_pkg::PIX_W-1:0] r_bright;
    logic [rthp_pkg::PIX_W-1:0] n_hue;
    logic [rthp_pkg::PIX_W-1:0] n_sat;
    logic [rthp_pkg::PIX_W-1:0] q;
    logic [rthp_pkg::PIX_W-1:0] step;

    assign o_ready = !r_valid || o_hsv.ready;

    // Floor for blue and green sectors, truncation with wrap for red
    always_comb begin
        q    = i_word.hue_q;
        step = q + rthp_pkg::PIX_W'(i_word.hue_rem != '0);
        case (i_word.sector)
            rthp_pkg::SEC_BLUE: begin
                n_hue = i_word.neg ? (rthp_pkg::HUE_BLUE - step) : (rthp_pkg::HUE_BLUE + q);
            end
            rthp_pkg::SEC_GREEN: begin
                n_hue = i_word.neg ? (rthp_pkg::HUE_GREEN - step) : (rthp_pkg::HUE_GREEN + q);
            end
            default: begin
                n_hue = (i_word.neg && (q != '0)) ? (rthp_pkg::HUE_WRAP - q) : q;
            end
        endcase
        n_sat = i_word.sat_q;
        // Equal channels: drop hue and saturation to zero
        if (i_word.zero) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= i_word.bright;
        end
    end

    assign o_hsv.valid      = r_valid;
    assign o_hsv.hue        = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.brightness = r_bright;

    // Hue stays below a full turn (0..179 half degrees)
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_hue <= rthp_pkg::HUE_MAX))
        else $error("hue out of range");

    // A nonzero hue needs a nonzero delta, so saturation is nonzero too
    a_hue_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_hue != '0)) |-> (r_sat != '0))
        else $error("hue without saturation");

    // Black pixel gives zero hue and saturation
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_bright == '0)) |-> ((r_hue == '0) && (r_sat == '0)))
        else $error("black pixel with color");

    // An accepted word shows up as a valid result on the next cycle
    a_word_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> r_valid)
        else $error("accepted word not held");

endmodule

>>> design/rgb_to_hsv_pixel_unit.sv
// Top level of the RGB to HSV pixel pipeline.
//
// Usage:
//   i_pix  : sink channel carrying one pixel per word (blue, green, red bytes).
//   o_hsv  : source channel carrying hue (half degrees, 0..179), saturation and
//            brightness for each pixel, in input order.
//   A word moves when valid and ready are both high at a rising edge of i_clk.
// Stages: from acceptance to o_hsv.valid a pixel passes two front stages
//   (maximum and delta, then the dividends), eight division stages that each
//   resolve one quotient bit of both divisions, and the output register.
// Throughput: one pixel per cycle while o_hsv.ready is high; the eight-step
//   restoring divider is fully pipelined; every stage takes one word per cycle.
// Reset: i_rst_n low at a clock edge clears all valid bits; the pipeline is
//   empty and i_pix.ready is high after reset.
// Stall: when o_hsv.ready is low, the result holds and words close up behind
//   it into empty stages; i_pix.ready falls only once every stage is full.
module rgb_to_hsv_pixel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rthp_pix_if.sink    i_pix,
    rthp_hsv_if.source  o_hsv
);

    logic                valid [rthp_pkg::DIV_STEPS+1];
    logic                ready [rthp_pkg::DIV_STEPS+1];
    rthp_pkg::t_div_word word  [rthp_pkg::DIV_STEPS+1];

    // Maximum, delta and dividends
    rthp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_valid (valid[0]),
        .o_word  (word[0]),
        .i_ready (ready[0])
    );

    // One quotient bit per stage
    for (genvar g = 0; g < rthp_pkg::DIV_STEPS; g++) begin : g_div
        rthp_div_stage u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[g]),
            .i_word  (word[g]),
            .o_ready (ready[g]),
            .o_valid (valid[g+1]),
            .o_word  (word[g+1]),
            .i_ready (ready[g+1])
        );
    end

    // Hue correction and output register
    rthp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (valid[rthp_pkg::DIV_STEPS]),
        .i_word  (word[rthp_pkg::DIV_STEPS]),
        .o_ready (ready[rthp_pkg::DIV_STEPS]),
        .o_hsv   (o_hsv)
    );

endmodule

>>> test/tb.sv
// Testbench for the RGB to HSV pixel pipeline: random and directed pixels, scoreboard check.
`timescale 1ns / 100ps

typedef logic [rthp_pkg::PIX_W-1:0] t_chan;

// Predict HSV words from accepted pixels and match them against the output stream
class hsv_scoreboard;
    typedef struct {
        t_chan hue;
        t_chan saturation;
        t_chan brightness;
    } t_hsv_word;

    t_hsv_word expected_hsv[$];
    int        mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Integer quotient rounded toward minus infinity
    static function int floor_quot(int num, int den);
        int q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q--;
        return q;
    endfunction

    // Work out the HSV word for one accepted pixel and queue it
    function void note_pixel(t_chan blue, t_chan green, t_chan red);
        int               bl;
        int               gr;
        int               rd;
        int               peak;
        int               low;
        int               delta;
        int               num;
        int               hue;
        int               sat;
        rthp_pkg::t_sector sec;
        t_hsv_word        word;
        bl = blue;
        gr = green;
        rd = red;
        // Pick the maximum: green wins ties with blue, red wins ties with either
        if (bl > gr) begin
            sec  = rthp_pkg::SEC_BLUE;
            peak = bl;
        end else begin
            sec  = rthp_pkg::SEC_GREEN;
            peak = gr;
        end
        if (!(peak > rd)) begin
            sec  = rthp_pkg::SEC_RED;
            peak = rd;
        end
        case (sec)
            rthp_pkg::SEC_BLUE: begin
                low = (gr < rd) ? gr : rd;
                num = (rd - gr) * 30;
            end
            rthp_pkg::SEC_GREEN: begin
                low = (rd < bl) ? rd : bl;
                num = (bl - rd) * 30;
            end
            default: begin
                low = (bl < gr) ? bl : gr;
                num = (gr - bl) * 30;
            end
        endcase
        delta = peak - low;
        hue   = 0;
        sat   = 0;
        // Gray pixels keep hue and saturation at zero
        if (delta != 0) begin
            case (sec)
                rthp_pkg::SEC_BLUE:
                    hue = int'(rthp_pkg::HUE_BLUE) + floor_quot(num, delta);
                rthp_pkg::SEC_GREEN:
                    hue = int'(rthp_pkg::HUE_GREEN) + floor_quot(num, delta);
                default: begin
                    // Red sector truncates toward zero and wraps negative hues
                    hue = num / delta;
                    if (hue < 0)
                        hue += int'(rthp_pkg::HUE_WRAP);
                end
            endcase
            sat = (delta * 255) / peak;
        end
        word.hue        = t_chan'(hue);
        word.saturation = t_chan'(sat);
        word.brightness = t_chan'(peak);
        expected_hsv = {expected_hsv, word};
    endfunction

    // Compare one output word with the oldest prediction
    function void check_hsv(t_chan hue, t_chan saturation, t_chan brightness);
        t_hsv_word want;
        if (expected_hsv.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected HSV word hue=%0d sat=%0d bright=%0d",
                         $time, hue, saturation, brightness);
            return;
        end
        want = expected_hsv.pop_front();
        if (want.hue !== hue || want.saturation !== saturation ||
            want.brightness !== brightness) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: HSV mismatch exp h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                         $time, want.hue, want.saturation, want.brightness,
                         hue, saturation, brightness);
        end
    endfunction

    function int pending();
        return expected_hsv.size();
    endfunction
endclass

module tb;
    localparam int PIXEL_COUNT = 1700;
    localparam int QUIET_COUNT = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 30;

    logic i_clk;
    logic i_rst_n;

    rthp_pix_if pix_bus ();
    rthp_hsv_if hsv_bus ();

    rgb_to_hsv_pixel_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_hsv   (hsv_bus)
    );

    hsv_scoreboard sb = new();

    int cycle_count = 0;
    int gap_odds    = 0;
    int stall_odds  = 0;
    bit quiet_tail  = 1'b0;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Drive every input to a known value from time zero
    initial begin
        i_rst_n          = 1'b0;
        pix_bus.valid    = 1'b0;
        pix_bus.blue     = '0;
        pix_bus.green    = '0;
        pix_bus.red      = '0;
        hsv_bus.ready    = 1'b0;
    end

    // Abort on a hung pipeline
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Observe accepted pixels and produced HSV words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_bus.valid && pix_bus.ready)
                sb.note_pixel(pix_bus.blue, pix_bus.green, pix_bus.red);
            if (hsv_bus.valid && hsv_bus.ready)
                sb.check_hsv(hsv_bus.hue, hsv_bus.saturation, hsv_bus.brightness);
        end
    end

    // Stall the output in random bursts; re-roll the odds now and then
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) == 0)
                stall_odds = $urandom_range(0, 2) * 3;
            if (!quiet_tail && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
                stall = $urandom_range(1, 9);
                hsv_bus.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                hsv_bus.ready <= 1'b1;
            end
        end
    end

    // Offer one pixel, with an optional idle burst first, and hold it until taken
    task automatic send_pixel(t_chan blue, t_chan green, t_chan red);
        int gap;
        gap = 0;
        if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
            gap = $urandom_range(1, 9);
        repeat (gap) begin
            @(negedge i_clk);
            pix_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        pix_bus.valid <= 1'b1;
        pix_bus.blue  <= blue;
        pix_bus.green <= green;
        pix_bus.red   <= red;
        do
            @(posedge i_clk);
        while (!pix_bus.ready);
    endtask

    // Hold off new pixels until every predicted word has come out
    task automatic drain_pipeline();
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Random pixel with a bias toward gray, ties, extremes and small deltas
    task automatic send_random_pixel();
        t_chan b;
        t_chan g;
        t_chan r;
        t_chan v;
        t_chan w;
        b = t_chan'($urandom);
        g = t_chan'($urandom);
        r = t_chan'($urandom);
        v = t_chan'($urandom);
        w = t_chan'($urandom_range(0, v));
        case ($urandom_range(0, 9))
            0: begin
                b = v;
                g = v;
                r = v;
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: begin b = v; g = v; r = w; end
                    1: begin b = v; r = v; g = w; end
                    default: begin g = v; r = v; b = w; end
                endcase
            end
            2: begin
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            3: begin
                b = v;
                g = v ^ t_chan'($urandom_range(0, 3));
                r = v ^ t_chan'($urandom_range(0, 3));
            end
            default: ;
        endcase
        send_pixel(b, g, r);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: gray, each sector, every tie, hue wrap and extremes
        gap_odds = 2;
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd77,  8'd77,  8'd77);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd9,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd9,   8'd255);
        send_pixel(8'd255, 8'd9,   8'd0);
        send_pixel(8'd255, 8'd0,   8'd9);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd253);
        send_pixel(8'd128, 8'd64,  8'd200);
        send_pixel(8'd10,  8'd200, 8'd100);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd170, 8'd85,  8'd170);
        drain_pipeline();

        // Random stream; pause once midway and go quiet at the tail
        for (int n = 0; n < PIXEL_COUNT; n++) begin
            if (n % 64 == 0)
                gap_odds = $urandom_range(0, 2) * 4;
            if (n == PIXEL_COUNT / 2)
                drain_pipeline();
            if (n == PIXEL_COUNT - QUIET_COUNT)
                quiet_tail = 1'b1;
            send_random_pixel();
        end
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;

        // Wait out the pipeline, then give the verdict
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/rthp_pkg.sv
design/rthp_if.sv
design/rthp_front.sv
design/rthp_div_stage.sv
design/rthp_back.sv
design/rgb_to_hsv_pixel_unit.sv
test/tb.sv
